[rtl/core/pwa_pkg.sv]
// ----------------------------------------------------------------------------
// pwa_pkg
// Shared constants, register codes and types for the perspective warp
// address block.
// ----------------------------------------------------------------------------
package pwa_pkg;

  localparam int COORD_BITS_DEF = 14;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEN    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 4'd7;

  // 1.0 in Q2.30; also the divisor that turns the divide into plain affine rounding
  localparam logic [31:0] ONE_Q2_30 = 32'h4000_0000;

  localparam logic [63:0] RST_ROW0   = 64'h0000_0000_0004_0000;
  localparam logic [63:0] RST_ROW1   = 64'h0004_0000_0000_0000;
  localparam logic [63:0] RST_ROW2   = 64'h0;
  localparam logic [63:0] RST_OFFS   = 64'h0;
  localparam logic [31:0] RST_DEN    = ONE_Q2_30;
  localparam logic [14:0] RST_WIDTH  = 15'd16384;
  localparam logic [14:0] RST_HEIGHT = 15'd16384;
  localparam logic        RST_MODE   = 1'b1;

  // numerator scaled by 2^12 (Q.18 vs Q.30) and by 2 for the rounding bit
  localparam int NUM_SHIFT = 13;

  typedef struct packed {
    logic w_zero;
    logic neg_x;
    logic neg_y;
  } pwa_flags_t;

  // width of the divider remainder path
  function automatic int rem_w(input int c);
    rem_w = (2 * c + 36 > c + 47) ? 2 * c + 36 : c + 47;
  endfunction

endpackage

[rtl/core/pwa_in_if.sv]
// ----------------------------------------------------------------------------
// pwa_in_if
// Destination coordinate channel.
// ----------------------------------------------------------------------------
interface pwa_in_if #(
  parameter int COORD_BITS = pwa_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] dest_x;
  logic [COORD_BITS-1:0] dest_y;

  modport source (output valid, dest_x, dest_y, input ready);
  modport sink   (input valid, dest_x, dest_y, output ready);
endinterface

[rtl/core/pwa_out_if.sv]
// ----------------------------------------------------------------------------
// pwa_out_if
// Source address result channel.
// ----------------------------------------------------------------------------
interface pwa_out_if #(
  parameter int COORD_BITS = pwa_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] src_x;
  logic [COORD_BITS-1:0] src_y;
  logic                  inside_res;

  modport source (output valid, src_x, src_y, inside_res, input ready);
  modport sink   (input valid, src_x, src_y, inside_res, output ready);
endinterface

[rtl/core/pwa_cfg_if.sv]
// ----------------------------------------------------------------------------
// pwa_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface pwa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pwa_pkg::CFG_IDX_W-1:0]  index;
  logic [pwa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/pwa_divider.sv]
// ----------------------------------------------------------------------------
// pwa_divider
// Pipelined restoring divider, two numerators over one divisor, one
// quotient bit per stage. The top quotient bit marks an overflowed result.
// ----------------------------------------------------------------------------
module pwa_divider #(
  parameter  int COORD_BITS = pwa_pkg::COORD_BITS_DEF,
  localparam int RW         = pwa_pkg::rem_w(COORD_BITS),
  localparam int QW         = COORD_BITS + 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RW-1:0]      in_rem_x,
  input  logic [RW-1:0]      in_rem_y,
  input  logic [RW-1:0]      in_dvs,
  input  pwa_pkg::pwa_flags_t in_flags,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [QW-1:0]      out_q_x,
  output logic [QW-1:0]      out_q_y,
  output pwa_pkg::pwa_flags_t out_flags
);

  localparam int NS = QW;

  logic                v_r   [NS];
  logic                rdy   [NS];
  logic [RW-1:0]       rx_r  [NS];
  logic [RW-1:0]       ry_r  [NS];
  logic [RW-1:0]       d_r   [NS];
  logic [QW-1:0]       qx_r  [NS];
  logic [QW-1:0]       qy_r  [NS];
  pwa_pkg::pwa_flags_t fl_r  [NS];

  genvar s;
  for (s = 0; s < NS; s++) begin : g_step
    localparam int SH = NS - 1 - s;
    logic                v_i;
    logic                rdy_nx;
    logic [RW-1:0]       rx_i;
    logic [RW-1:0]       ry_i;
    logic [RW-1:0]       d_i;
    logic [QW-1:0]       qx_i;
    logic [QW-1:0]       qy_i;
    pwa_pkg::pwa_flags_t fl_i;
    logic [RW-1:0]       tx;
    logic                ge_x;
    logic                ge_y;

    if (s == 0) begin : g_first
      assign v_i  = in_valid;
      assign rx_i = in_rem_x;
      assign ry_i = in_rem_y;
      assign d_i  = in_dvs;
      assign qx_i = '0;
      assign qy_i = '0;
      assign fl_i = in_flags;
    end else begin : g_next
      assign v_i  = v_r[s-1];
      assign rx_i = rx_r[s-1];
      assign ry_i = ry_r[s-1];
      assign d_i  = d_r[s-1];
      assign qx_i = qx_r[s-1];
      assign qy_i = qy_r[s-1];
      assign fl_i = fl_r[s-1];
    end

    if (s == NS - 1) begin : g_last
      assign rdy_nx = out_ready;
    end else begin : g_mid
      assign rdy_nx = rdy[s+1];
    end

    assign rdy[s] = !v_r[s] || rdy_nx;
    assign tx     = d_i << SH;
    assign ge_x   = rx_i >= tx;
    assign ge_y   = ry_i >= tx;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rx_r[s] <= ge_x ? rx_i - tx : rx_i;
        ry_r[s] <= ge_y ? ry_i - tx : ry_i;
        qx_r[s] <= {qx_i[QW-2:0], ge_x};
        qy_r[s] <= {qy_i[QW-2:0], ge_y};
        d_r[s]  <= d_i;
        fl_r[s] <= fl_i;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_q_x   = qx_r[NS-1];
  assign out_q_y   = qy_r[NS-1];
  assign out_flags = fl_r[NS-1];

endmodule

[rtl/core/perspective_warp_address.sv]
// ----------------------------------------------------------------------------
// perspective_warp_address
// Maps destination pixels through a loaded inverse homography to rounded
// source pixel addresses with an inside-image flag.
// ----------------------------------------------------------------------------
// Takes one destination pixel per clock while the output is not stalled and
// returns its source address through registered stages: the coefficient
// multiplies, the row sums, sign and magnitude, the restoring divider (one
// quotient bit per stage) and one output register. Affine mode runs the same
// path with the divisor forced to 1.0, so latency does not depend on the mode.
// Registers are written through the cfg channel, which is always ready;
// write them only while no pixel is in flight.
module perspective_warp_address #(
  parameter int COORD_BITS = pwa_pkg::COORD_BITS_DEF
) (
  input logic            clk,
  input logic            rst_n,
  pwa_in_if.sink         in_ch,
  pwa_out_if.source      out_ch,
  pwa_cfg_if.sink        cfg_ch
);

  localparam int PW = COORD_BITS + 33;
  localparam int NW = COORD_BITS + 35;
  localparam int RW = pwa_pkg::rem_w(COORD_BITS);
  localparam int QW = COORD_BITS + 3;
  localparam int MW = COORD_BITS + 2;
  localparam int CW = (MW > 15) ? MW : 15;

  // configuration registers
  logic [63:0] row0_r, row1_r, row2_r, offs_r;
  logic [31:0] den_r;
  logic [14:0] width_r, height_r;
  logic        persp_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r   <= pwa_pkg::RST_ROW0;
      row1_r   <= pwa_pkg::RST_ROW1;
      row2_r   <= pwa_pkg::RST_ROW2;
      offs_r   <= pwa_pkg::RST_OFFS;
      den_r    <= pwa_pkg::RST_DEN;
      width_r  <= pwa_pkg::RST_WIDTH;
      height_r <= pwa_pkg::RST_HEIGHT;
      persp_r  <= pwa_pkg::RST_MODE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pwa_pkg::REG_ROW0:   row0_r   <= cfg_ch.data;
        pwa_pkg::REG_ROW1:   row1_r   <= cfg_ch.data;
        pwa_pkg::REG_ROW2:   row2_r   <= cfg_ch.data;
        pwa_pkg::REG_OFFS:   offs_r   <= cfg_ch.data;
        pwa_pkg::REG_DEN:    den_r    <= cfg_ch.data[31:0];
        pwa_pkg::REG_WIDTH:  width_r  <= cfg_ch.data[14:0];
        pwa_pkg::REG_HEIGHT: height_r <= cfg_ch.data[14:0];
        pwa_pkg::REG_MODE:   persp_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // ready chain
  logic rdy1, rdy2, rdy3, rdy_o, div_in_ready;
  logic v1_r, v2_r, v3_r, vo_r;

  assign rdy_o       = !vo_r || out_ch.ready;
  assign rdy3        = !v3_r || div_in_ready;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // stage 1: six coefficient products
  logic signed [COORD_BITS:0] xs, ys;
  logic signed [PW-1:0]       p_nxt [6];
  logic signed [PW-1:0]       p_r   [6];

  always_comb begin
    xs       = signed'({1'b0, in_ch.dest_x});
    ys       = signed'({1'b0, in_ch.dest_y});
    p_nxt[0] = PW'(signed'(row0_r[31:0]))  * PW'(xs);
    p_nxt[1] = PW'(signed'(row0_r[63:32])) * PW'(ys);
    p_nxt[2] = PW'(signed'(row1_r[31:0]))  * PW'(xs);
    p_nxt[3] = PW'(signed'(row1_r[63:32])) * PW'(ys);
    p_nxt[4] = PW'(signed'(row2_r[31:0]))  * PW'(xs);
    p_nxt[5] = PW'(signed'(row2_r[63:32])) * PW'(ys);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 6; i++) p_r[i] <= p_nxt[i];
    end
  end

  // stage 2: row sums
  logic signed [NW-1:0] nx_nxt, ny_nxt, w_nxt;
  logic signed [NW-1:0] nx_r, ny_r, w_r;

  always_comb begin
    nx_nxt = NW'(p_r[0]) + NW'(p_r[1]) + NW'(signed'(offs_r[31:0]));
    ny_nxt = NW'(p_r[2]) + NW'(p_r[3]) + NW'(signed'(offs_r[63:32]));
    w_nxt  = NW'(p_r[4]) + NW'(p_r[5]) + NW'(signed'(den_r));
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      nx_r <= nx_nxt;
      ny_r <= ny_nxt;
      w_r  <= w_nxt;
    end
  end

  // stage 3: signs and magnitudes, divider operands
  logic signed [NW-1:0] weff;
  logic [NW-1:0]        ax, ay, aw;
  logic [RW-1:0]        remx_nxt, remy_nxt, dvs_nxt;
  logic [RW-1:0]        remx_r, remy_r, dvs_r;
  pwa_pkg::pwa_flags_t  fl_nxt, fl3_r;

  always_comb begin
    weff            = persp_r ? w_r : NW'(signed'(pwa_pkg::ONE_Q2_30));
    ax              = nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
    ay              = ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
    aw              = weff[NW-1] ? NW'(-weff) : NW'(weff);
    remx_nxt        = RW'(ax) << pwa_pkg::NUM_SHIFT;
    remy_nxt        = RW'(ay) << pwa_pkg::NUM_SHIFT;
    dvs_nxt         = RW'(aw);
    fl_nxt.w_zero   = persp_r && (w_r == '0);
    fl_nxt.neg_x    = nx_r[NW-1] ^ weff[NW-1];
    fl_nxt.neg_y    = ny_r[NW-1] ^ weff[NW-1];
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      dvs_r  <= dvs_nxt;
      fl3_r  <= fl_nxt;
    end
  end

  // divider
  logic                div_out_valid;
  logic [QW-1:0]       qx, qy;
  pwa_pkg::pwa_flags_t div_flags;

  pwa_divider #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_in_ready),
    .in_rem_x  (remx_r),
    .in_rem_y  (remy_r),
    .in_dvs    (dvs_r),
    .in_flags  (fl3_r),
    .out_valid (div_out_valid),
    .out_ready (rdy_o),
    .out_q_x   (qx),
    .out_q_y   (qy),
    .out_flags (div_flags)
  );

  // output stage: round the doubled quotient and range check
  logic [QW-1:0]         qx_inc, qy_inc;
  logic [MW-1:0]         mx, my;
  logic                  okx, oky, ok;
  logic [COORD_BITS-1:0] sx_r, sy_r;
  logic                  inside_r;

  always_comb begin
    qx_inc = {1'b0, qx[QW-2:0]} + QW'(1);
    qy_inc = {1'b0, qy[QW-2:0]} + QW'(1);
    mx     = qx_inc[QW-1:1];
    my     = qy_inc[QW-1:1];
    okx    = !qx[QW-1] && (!div_flags.neg_x || mx == '0) &&
             (mx[MW-1:COORD_BITS] == '0) && (CW'(mx) < CW'(width_r));
    oky    = !qy[QW-1] && (!div_flags.neg_y || my == '0) &&
             (my[MW-1:COORD_BITS] == '0) && (CW'(my) < CW'(height_r));
    ok     = okx && oky && !div_flags.w_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (rdy_o) begin
      vo_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      sx_r     <= ok ? mx[COORD_BITS-1:0] : '0;
      sy_r     <= ok ? my[COORD_BITS-1:0] : '0;
      inside_r <= ok;
    end
  end

  assign out_ch.valid      = vo_r;
  assign out_ch.src_x      = sx_r;
  assign out_ch.src_y      = sy_r;
  assign out_ch.inside_res = inside_r;

  // checks
  a_inside_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.inside_res |->
      (CW'(out_ch.src_x) < CW'(width_r)) && (CW'(out_ch.src_y) < CW'(height_r)))
    else $error("inside beat with address outside the image");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.inside_res |-> out_ch.src_x == '0 && out_ch.src_y == '0)
    else $error("outside beat with nonzero address");

  a_affine_no_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_out_valid && div_flags.w_zero |-> persp_r)
    else $error("zero divisor flagged in affine mode");

  a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    div_out_valid && rdy_o |=> out_ch.valid)
    else $error("divider result dropped before output register");

endmodule
